[rtl/core/clp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Near-plane clipper package
// Shared constants, controller states and the command and status structs.
// ----------------------------------------------------------------------------
package clp_pkg;

    localparam int NATTR         = 9;
    localparam int DEF_WORD_BITS = 32;
    localparam int BUF_MAX       = 5;
    localparam int POLY_MAX      = 4;
    localparam int IDX_Z         = 2;
    localparam int IDX_W         = 3;

    localparam logic [1:0] CORNER_LAST = 2'd2;
    localparam logic [1:0] EDGE_LAST   = 2'd2;
    localparam logic [3:0] ATTR_LAST   = 4'd8;
    localparam logic [1:0] FAN_LAST    = 2'd2;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_CHECK,
        ST_EDGE_LOAD,
        ST_EDGE_TEST,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_APP_S,
        ST_APP_E,
        ST_NEXT_EDGE,
        ST_FINAL,
        ST_FAN_SETUP,
        ST_EMIT_FAN,
        ST_EMIT_PASS
    } t_state;

    typedef struct packed {
        logic       load_corner;
        logic [1:0] corner_idx;
        logic       poly_clr;
        logic       load_edge;
        logic [1:0] edge_idx;
        logic       div_start;
        logic [3:0] attr_idx;
        logic       app_s;
        logic       app_e;
        logic       finalize;
        logic       emit;
        logic       emit_pass;
        logic [2:0] emit_idx;
        logic       emit_last;
    } t_cmd;

    typedef struct packed {
        logic       all_in;
        logic       ia;
        logic       ib;
        logic       div_done;
        logic       out_free;
        logic [2:0] n;
    } t_sts;

endpackage
`default_nettype wire

[rtl/core/triangle_near_plane_clipper.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Triangle near-plane clipper
// Collects three vertices, clips the triangle at z = -w and sends a fan.
//
// Channel  Dir  Request            Accepted when
// s_axis   in   one vertex         s_axis_tvalid && s_axis_tready
// m_axis   out  one fan vertex     m_axis_tvalid && m_axis_tready
//
// A vertex that does not complete a triangle is taken straight away in the
// collect state. A triangle inside the near plane passes the check state,
// then is sent at one output vertex per cycle while the output register is free.
// Each crossing edge adds nine divisions in the bit-serial divider, which
// finishes early when the numerator or the denominator is zero. Input
// stalls while a triangle is clipped or sent.
// Reset is synchronous and clears all control state.
// ----------------------------------------------------------------------------
module triangle_near_plane_clipper
    import clp_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    // pos_x, pos_y, pos_z, pos_w, norm_x, norm_y, norm_z, tex_u, tex_v
    input  wire  [((NATTR*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    // out_pos_x, out_pos_y, out_pos_z, out_pos_w, out_norm_x, out_norm_y,
    // out_norm_z, out_tex_u, out_tex_v
    output logic [((NATTR*WORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    output logic                m_axis_tlast
);

    localparam int TDW = ((NATTR * WORD_BITS + 7) / 8) * 8;

    t_cmd                         w_cmd;
    t_sts                         w_sts;
    logic [NATTR*WORD_BITS-1:0]   w_out_data;

    clp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    clp_dp #(
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (s_axis_tdata[NATTR*WORD_BITS-1:0]),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (w_out_data),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = TDW'(w_out_data);

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("Vertex emitted into a full output register.");

    a_no_input_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.div_done |-> !s_axis_tready)
        else $error("Input accepted while an edge was being divided.");

    a_fan_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && !w_cmd.emit_pass) |-> (w_sts.n >= 3'd3 && w_sts.n <= 3'd4))
        else $error("Fan emitted from a polygon of bad size.");

endmodule
`default_nettype wire

[rtl/core/clp_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clipper divider
// Restoring divider, one quotient bit per cycle, with saturation to the word.
// ----------------------------------------------------------------------------
module clp_div
    import clp_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire [2*WORD_BITS+1:0]   i_num,
    input  wire [WORD_BITS+1:0]     i_den,
    input  wire                     i_neg,
    input  wire                     i_sn,
    input  wire                     i_num_zero,
    input  wire                     i_den_zero,
    output logic                    o_done,
    output logic [WORD_BITS-1:0]    o_quot
);

    localparam int NB = 2 * WORD_BITS + 2;
    localparam int DB = WORD_BITS + 2;
    localparam int CW = $clog2(NB + 1);
    localparam logic [WORD_BITS-1:0] SMAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
    localparam logic [WORD_BITS-1:0] SMIN = {1'b1, {(WORD_BITS - 1){1'b0}}};

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [DB-1:0]        r_rem;
    logic [DB-1:0]        r_den;
    logic [NB-1:0]        r_quo;
    logic                 r_neg;
    logic [WORD_BITS-1:0] r_res;

    logic [DB:0]          w_rr;
    logic                 w_ge;
    logic [DB:0]          w_diff;
    logic                 w_pos_ovf;
    logic                 w_neg_ovf;
    logic [WORD_BITS-1:0] w_sat;

    always_comb begin
        w_rr      = {r_rem, r_quo[NB-1]};
        w_ge      = (w_rr >= {1'b0, r_den});
        w_diff    = w_rr - {1'b0, r_den};
        w_pos_ovf = |r_quo[NB-1:WORD_BITS-1];
        w_neg_ovf = (|r_quo[NB-1:WORD_BITS])
                  || (r_quo[WORD_BITS-1] && (|r_quo[WORD_BITS-2:0]));
        if (r_neg) begin
            w_sat = w_neg_ovf ? SMIN : (~r_quo[WORD_BITS-1:0] + 1'b1);
        end else begin
            w_sat = w_pos_ovf ? SMAX : r_quo[WORD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_num_zero) begin
                    r_res  <= '0;
                    r_done <= 1'b1;
                end else if (i_den_zero) begin
                    r_res  <= i_sn ? SMIN : SMAX;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(NB);
                    r_rem  <= '0;
                    r_den  <= i_den;
                    r_quo  <= i_num;
                    r_neg  <= i_neg;
                end
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= w_sat;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                    r_rem <= w_ge ? w_diff[DB-1:0] : w_rr[DB-1:0];
                    r_quo <= {r_quo[NB-2:0], w_ge};
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_res;

endmodule
`default_nettype wire

[rtl/core/clp_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clipper datapath
// Corner and edge registers, interpolation, polygon buffer and output register.
// ----------------------------------------------------------------------------
module clp_dp
    import clp_pkg::*;
#(
    parameter int WORD_BITS = DEF_WORD_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire  [NATTR*WORD_BITS-1:0]    i_in_data,
    input  t_cmd                          i_cmd,
    output t_sts                          o_sts,
    input  wire                           i_out_ready,
    output logic                          o_out_valid,
    output logic [NATTR*WORD_BITS-1:0]    o_out_data,
    output logic                          o_out_last
);

    localparam int W = WORD_BITS;

    typedef logic [NATTR-1:0][W-1:0] t_vtx;

    function automatic logic f_inside(t_vtx v);
        logic signed [W:0] d;
        d = $signed({v[IDX_Z][W-1], v[IDX_Z]}) + $signed({v[IDX_W][W-1], v[IDX_W]});
        return ($signed(v[IDX_W]) > 0) && (d > 0);
    endfunction

    t_vtx r_v [3];
    t_vtx r_a;
    t_vtx r_b;
    t_vtx r_nv;
    t_vtx r_buf [BUF_MAX];
    t_vtx r_first;
    t_vtx r_last;
    logic [2:0] r_n;

    logic [2*W:0]        r_p;
    logic [2*W:0]        r_q;
    logic                r_sp;
    logic                r_sq;
    logic signed [W+1:0] r_den;
    logic [3:0]          r_attr;
    logic                r_mv;

    logic                r_ov;
    t_vtx                r_od;
    logic                r_ol;

    logic signed [W:0]   w_da;
    logic signed [W:0]   w_db;
    logic [W:0]          w_mda;
    logic [W:0]          w_mdb;
    logic [W-1:0]        w_a0;
    logic [W-1:0]        w_a1;
    logic [W-1:0]        w_ma0;
    logic [W-1:0]        w_ma1;
    logic [2*W+1:0]      w_m;
    logic                w_sn;
    logic [W+1:0]        w_mden;
    logic                w_div_done;
    logic [W-1:0]        w_quot;
    logic                w_ia;
    logic                w_ib;
    t_vtx                w_s;
    t_vtx                w_e;
    logic                w_out_free;
    logic [2:0]          w_n1;

    always_comb begin
        w_da  = $signed({r_a[IDX_Z][W-1], r_a[IDX_Z]})
              + $signed({r_a[IDX_W][W-1], r_a[IDX_W]});
        w_db  = $signed({r_b[IDX_Z][W-1], r_b[IDX_Z]})
              + $signed({r_b[IDX_W][W-1], r_b[IDX_W]});
        w_mda = w_da[W] ? (~w_da + 1'b1) : w_da;
        w_mdb = w_db[W] ? (~w_db + 1'b1) : w_db;
        w_a0  = r_a[i_cmd.attr_idx];
        w_a1  = r_b[i_cmd.attr_idx];
        w_ma0 = w_a0[W-1] ? (~w_a0 + 1'b1) : w_a0;
        w_ma1 = w_a1[W-1] ? (~w_a1 + 1'b1) : w_a1;
    end

    always_comb begin
        if (r_sp == r_sq) begin
            w_m  = {1'b0, r_p} + {1'b0, r_q};
            w_sn = r_sp;
        end else if (r_p >= r_q) begin
            w_m  = {1'b0, r_p - r_q};
            w_sn = r_sp;
        end else begin
            w_m  = {1'b0, r_q - r_p};
            w_sn = r_sq;
        end
        w_mden = r_den[W+1] ? (~r_den + 1'b1) : r_den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= 1'b0;
        end else begin
            r_mv <= i_cmd.div_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_p    <= w_mdb * w_ma0;
            r_q    <= w_mda * w_ma1;
            r_sp   <= w_db[W] != w_a0[W-1];
            r_sq   <= !(w_da[W] != w_a1[W-1]);
            r_den  <= {w_db[W], w_db} - {w_da[W], w_da};
            r_attr <= i_cmd.attr_idx;
        end
    end

    clp_div #(
        .WORD_BITS (WORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_mv),
        .i_num      (w_m),
        .i_den      (w_mden),
        .i_neg      (w_sn != r_den[W+1]),
        .i_sn       (w_sn),
        .i_num_zero (w_m == '0),
        .i_den_zero (r_den == '0),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_nv[r_attr] <= w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_corner) begin
            r_v[i_cmd.corner_idx] <= i_in_data;
        end
        if (i_cmd.load_edge) begin
            unique case (i_cmd.edge_idx)
                2'd0: begin
                    r_a <= r_v[0];
                    r_b <= r_v[1];
                end
                2'd1: begin
                    r_a <= r_v[1];
                    r_b <= r_v[2];
                end
                default: begin
                    r_a <= r_v[2];
                    r_b <= r_v[0];
                end
            endcase
        end
    end

    always_comb begin
        w_ia = f_inside(r_a);
        w_ib = f_inside(r_b);
        w_s  = w_ia ? r_a : r_nv;
        w_e  = w_ib ? r_b : r_nv;
        w_n1 = ((r_n >= 3'd3) && (r_last == r_first)) ? (r_n - 1'b1) : r_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n <= '0;
        end else if (i_cmd.poly_clr) begin
            r_n <= '0;
        end else if (i_cmd.finalize) begin
            r_n <= (w_n1 > 3'(POLY_MAX)) ? 3'(POLY_MAX) : w_n1;
        end else if ((i_cmd.app_s && ((r_n == '0) || (r_last != w_s)))
                     || i_cmd.app_e) begin
            if (r_n < 3'(BUF_MAX)) begin
                r_n <= r_n + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_cmd.app_s && ((r_n == '0) || (r_last != w_s))) || i_cmd.app_e) begin
            if (r_n < 3'(BUF_MAX)) begin
                r_buf[r_n] <= i_cmd.app_e ? w_e : w_s;
                r_last     <= i_cmd.app_e ? w_e : w_s;
                if (r_n == '0) begin
                    r_first <= i_cmd.app_e ? w_e : w_s;
                end
            end
        end
    end

    assign w_out_free = !r_ov || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_od <= i_cmd.emit_pass ? r_v[i_cmd.emit_idx[1:0]] : r_buf[i_cmd.emit_idx];
            r_ol <= i_cmd.emit_last;
        end
    end

    always_comb begin
        o_sts.all_in   = f_inside(r_v[0]) && f_inside(r_v[1]) && f_inside(r_v[2]);
        o_sts.ia       = w_ia;
        o_sts.ib       = w_ib;
        o_sts.div_done = w_div_done;
        o_sts.out_free = w_out_free;
        o_sts.n        = r_n;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;
    assign o_out_last  = r_ol;

endmodule
`default_nettype wire

[rtl/core/clp_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Clipper controller
// Sequences corner collection, edge clipping, division and fan output.
// ----------------------------------------------------------------------------
module clp_ctrl
    import clp_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_sts  i_sts,
    output t_cmd  o_cmd
);

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_cc;
    logic [1:0] r_edge;
    logic [3:0] r_attr;
    logic [2:0] r_i;
    logic [1:0] r_k;
    logic       w_fan_end;

    assign w_fan_end = (r_k == FAN_LAST) && (3'(r_i + 3'd2) == i_sts.n);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (i_in_valid && (r_cc == CORNER_LAST)) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK:     n_state = i_sts.all_in ? ST_EMIT_PASS : ST_EDGE_LOAD;
            ST_EDGE_LOAD: n_state = ST_EDGE_TEST;
            ST_EDGE_TEST: begin
                priority if (!i_sts.ia && !i_sts.ib) begin
                    n_state = ST_NEXT_EDGE;
                end else if (i_sts.ia != i_sts.ib) begin
                    n_state = ST_DIV_START;
                end else begin
                    n_state = ST_APP_S;
                end
            end
            ST_DIV_START: n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (i_sts.div_done) begin
                    n_state = (r_attr == ATTR_LAST) ? ST_APP_S : ST_DIV_START;
                end
            end
            ST_APP_S:     n_state = ST_APP_E;
            ST_APP_E:     n_state = ST_NEXT_EDGE;
            ST_NEXT_EDGE: n_state = (r_edge == EDGE_LAST) ? ST_FINAL : ST_EDGE_LOAD;
            ST_FINAL:     n_state = ST_FAN_SETUP;
            ST_FAN_SETUP: n_state = (i_sts.n < 3'd3) ? ST_COLLECT : ST_EMIT_FAN;
            ST_EMIT_FAN: begin
                if (i_sts.out_free && w_fan_end) begin
                    n_state = ST_COLLECT;
                end
            end
            ST_EMIT_PASS: begin
                if (i_sts.out_free && (r_k == FAN_LAST)) begin
                    n_state = ST_COLLECT;
                end
            end
            default:      n_state = ST_COLLECT;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.corner_idx = r_cc;
        o_cmd.edge_idx   = r_edge;
        o_cmd.attr_idx   = r_attr;
        unique case (r_state)
            ST_COLLECT: begin
                o_in_ready        = 1'b1;
                o_cmd.load_corner = i_in_valid;
            end
            ST_CHECK:     o_cmd.poly_clr  = 1'b1;
            ST_EDGE_LOAD: o_cmd.load_edge = 1'b1;
            ST_DIV_START: o_cmd.div_start = 1'b1;
            ST_APP_S:     o_cmd.app_s     = 1'b1;
            ST_APP_E:     o_cmd.app_e     = 1'b1;
            ST_FINAL:     o_cmd.finalize  = 1'b1;
            ST_EMIT_FAN: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_last = w_fan_end;
                unique case (r_k)
                    2'd0:    o_cmd.emit_idx = 3'd0;
                    2'd1:    o_cmd.emit_idx = r_i;
                    default: o_cmd.emit_idx = r_i + 3'd1;
                endcase
            end
            ST_EMIT_PASS: begin
                o_cmd.emit      = i_sts.out_free;
                o_cmd.emit_pass = 1'b1;
                o_cmd.emit_idx  = {1'b0, r_k};
                o_cmd.emit_last = (r_k == FAN_LAST);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_cc    <= '0;
            r_edge  <= '0;
            r_attr  <= '0;
            r_i     <= 3'd1;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_COLLECT) && i_in_valid) begin
                r_cc <= (r_cc == CORNER_LAST) ? 2'd0 : r_cc + 2'd1;
            end
            if (r_state == ST_CHECK) begin
                r_edge <= '0;
                r_i    <= 3'd1;
                r_k    <= '0;
            end
            if ((r_state == ST_NEXT_EDGE) && (r_edge != EDGE_LAST)) begin
                r_edge <= r_edge + 2'd1;
            end
            if (r_state == ST_EDGE_TEST) begin
                r_attr <= '0;
            end
            if ((r_state == ST_DIV_WAIT) && i_sts.div_done) begin
                r_attr <= r_attr + 4'd1;
            end
            if (((r_state == ST_EMIT_FAN) || (r_state == ST_EMIT_PASS))
                && i_sts.out_free) begin
                if (r_k == FAN_LAST) begin
                    r_k <= '0;
                    r_i <= r_i + 3'd1;
                end else begin
                    r_k <= r_k + 2'd1;
                end
            end
        end
    end

endmodule
`default_nettype wire

[test/triangle_near_plane_clipper_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Triangle near-plane clipper testbench
// Streams vertex triples through the clipper and compares every fan vertex
// against an in-bench clip model, with random stalls on both channels.
// ----------------------------------------------------------------------------
module triangle_near_plane_clipper_tb;
    import clp_pkg::*;

    localparam int WB = DEF_WORD_BITS;
    localparam int DW = ((NATTR * WB + 7) / 8) * 8;
    localparam int WATCHDOG = 20000;

    typedef logic signed [WB-1:0] t_word;
    typedef t_word t_vtx [NATTR];

    typedef struct {
        logic [DW-1:0] data;
        logic          last;
    } t_fan_vtx;

    class fan_scoreboard;
        t_fan_vtx fan_q[$];
        t_vtx     corners[3];
        int       corner_cnt;
        int       errors;

        function logic signed [WB-1:0] lerp_attr(longint d0, longint d1,
                                                 longint a0, longint a1);
            logic signed [127:0] num;
            logic signed [127:0] den;
            logic signed [127:0] quo;
            longint smax;
            longint smin;
            smax = (64'sd1 <<< (WB - 1)) - 1;
            smin = -smax - 1;
            num = 128'(d1) * 128'(a0) - 128'(d0) * 128'(a1);
            den = 128'(d1 - d0);
            if (num == 0) return '0;
            if (den == 0) return (num < 0) ? WB'(smin) : WB'(smax);
            quo = num / den;
            if (quo > smax) return WB'(smax);
            if (quo < smin) return WB'(smin);
            return WB'(quo);
        endfunction

        function bit is_inside(t_vtx v);
            longint z;
            longint w;
            z = v[IDX_Z];
            w = v[IDX_W];
            return (w > 0) && (z + w > 0);
        endfunction

        function void add_poly(ref t_vtx poly[BUF_MAX], ref int n, input t_vtx v);
            if (n < BUF_MAX) begin
                poly[n] = v;
                n++;
            end
        endfunction

        function void clip_edge(t_vtx a, t_vtx b, ref t_vtx poly[BUF_MAX], ref int n);
            bit ia;
            bit ib;
            t_vtx s;
            t_vtx e;
            t_vtx nv;
            longint da;
            longint db;
            ia = is_inside(a);
            ib = is_inside(b);
            if (!ia && !ib) return;
            s = a;
            e = b;
            if (ia != ib) begin
                da = longint'(a[IDX_Z]) + longint'(a[IDX_W]);
                db = longint'(b[IDX_Z]) + longint'(b[IDX_W]);
                for (int j = 0; j < NATTR; j++) nv[j] = lerp_attr(da, db, a[j], b[j]);
                if (ia) e = nv;
                else s = nv;
            end
            if (n == 0 || poly[n-1] != s) add_poly(poly, n, s);
            add_poly(poly, n, e);
        endfunction

        function void push_vtx(t_vtx v, bit last);
            t_fan_vtx f;
            f.data = '0;
            for (int j = 0; j < NATTR; j++) f.data[j*WB +: WB] = v[j];
            f.last = last;
            fan_q.insert(fan_q.size(), f);
        endfunction

        function void note_request(logic [DW-1:0] data);
            t_vtx poly[BUF_MAX];
            int n;
            for (int j = 0; j < NATTR; j++) corners[corner_cnt][j] = data[j*WB +: WB];
            corner_cnt++;
            if (corner_cnt < 3) return;
            corner_cnt = 0;
            if (is_inside(corners[0]) && is_inside(corners[1]) && is_inside(corners[2])) begin
                for (int i = 0; i < 3; i++) push_vtx(corners[i], i == 2);
                return;
            end
            n = 0;
            clip_edge(corners[0], corners[1], poly, n);
            clip_edge(corners[1], corners[2], poly, n);
            clip_edge(corners[2], corners[0], poly, n);
            if (n >= 3 && poly[n-1] == poly[0]) n--;
            if (n > POLY_MAX) n = POLY_MAX;
            for (int i = 1; i + 1 < n; i++) begin
                push_vtx(poly[0], 1'b0);
                push_vtx(poly[i], 1'b0);
                push_vtx(poly[i+1], i + 2 == n);
            end
        endfunction

        function void check_result(logic [DW-1:0] data, logic last);
            t_fan_vtx f;
            string names[NATTR];
            names = '{"out_pos_x", "out_pos_y", "out_pos_z", "out_pos_w", "out_norm_x",
                      "out_norm_y", "out_norm_z", "out_tex_u", "out_tex_v"};
            if (fan_q.size() == 0) begin
                $error("unexpected fan vertex %h", data);
                errors++;
                return;
            end
            f = fan_q.pop_front();
            for (int j = 0; j < NATTR; j++) begin
                if (data[j*WB +: WB] !== f.data[j*WB +: WB]) begin
                    $error("%s expected %h actual %h", names[j],
                           f.data[j*WB +: WB], data[j*WB +: WB]);
                    errors++;
                end
            end
            if (last !== f.last) begin
                $error("last_of_face expected %b actual %b", f.last, last);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;
    logic          m_axis_tlast;

    fan_scoreboard sb = new();
    int send_idle_pct;
    int recv_idle_pct;
    int idle_cycles = 0;
    t_vtx tri_set[3];

    always #5 i_clk = ~i_clk;

    triangle_near_plane_clipper DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_vertex(input t_vtx v);
        logic [DW-1:0] d;
        d = '0;
        for (int j = 0; j < NATTR; j++) d[j*WB +: WB] = v[j];
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(5))
            0: return t_word'($urandom);
            1: return 32'sh7fffffff;
            2: return 32'sh80000000;
            default: return t_word'($urandom_range(32'h40000)) - 32'sh20000;
        endcase
    endfunction

    function automatic t_vtx rand_vtx();
        t_vtx v;
        for (int j = 0; j < NATTR; j++) v[j] = rand_word();
        if ($urandom_range(3) != 0) begin
            v[IDX_W] = t_word'($urandom_range(32'h30000));
            v[IDX_Z] = t_word'($urandom_range(32'h60000)) - 32'sh30000;
        end
        return v;
    endfunction

    function automatic t_vtx mk_vtx(t_word z, t_word w, t_word fill);
        t_vtx v;
        for (int j = 0; j < NATTR; j++) v[j] = fill + t_word'(j);
        v[IDX_Z] = z;
        v[IDX_W] = w;
        return v;
    endfunction

    task automatic send_triangle(input t_vtx a, input t_vtx b, input t_vtx c);
        send_vertex(a);
        send_vertex(b);
        send_vertex(c);
    endtask

    initial begin
        send_idle_pct = 25;
        recv_idle_pct = 88;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // All inside, all outside, one out, two out, duplicate corners,
        // a corner on the plane and field extremes.
        send_triangle(mk_vtx(0, 32'sh10000, 5), mk_vtx(0, 32'sh20000, 7),
                      mk_vtx(32'sh8000, 32'sh10000, 9));
        send_triangle(mk_vtx(-32'sh20000, 32'sh10000, 1), mk_vtx(0, -1, 2),
                      mk_vtx(0, 0, 3));
        send_triangle(mk_vtx(-32'sh30000, 32'sh10000, 32'sh7ffffff0),
                      mk_vtx(0, 32'sh10000, -32'sh7ffffff0), mk_vtx(0, 32'sh20000, 0));
        send_triangle(mk_vtx(-32'sh30000, 32'sh10000, 11), mk_vtx(-32'sh20000, 32'sh10000, 4),
                      mk_vtx(0, 32'sh10000, 6));
        send_triangle(mk_vtx(0, 32'sh10000, 1), mk_vtx(0, 32'sh10000, 1),
                      mk_vtx(-32'sh20000, 32'sh10000, 1));
        send_triangle(mk_vtx(-32'sh10000, 32'sh10000, 2), mk_vtx(0, 32'sh10000, 2),
                      mk_vtx(32'sh10000, 32'sh10000, 2));
        send_triangle(mk_vtx(32'sh80000000, 32'sh7fffffff, 32'sh80000000),
                      mk_vtx(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff),
                      mk_vtx(32'sh7fffffff, 32'sh7fffffff, -1));
        send_triangle(mk_vtx(-32'sh7fffffff, 32'sh1, 32'sh7fffffff), mk_vtx(0, 32'sh7fffffff, 0),
                      mk_vtx(32'sh80000000, 32'sh7fffffff, 32'sh80000000));

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 88 : 0;
            recv_idle_pct = (phase == 0) ? 88 : (phase == 1) ? 25 : 0;
            for (int t = 0; t < 34; t++) begin
                for (int i = 0; i < 3; i++) tri_set[i] = rand_vtx();
                if ($urandom_range(7) == 0) tri_set[1] = tri_set[0];
                send_triangle(tri_set[0], tri_set[1], tri_set[2]);
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.fan_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (sb.errors == 0 && sb.fan_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

[sim.f]
rtl/core/clp_pkg.sv
rtl/core/clp_div.sv
rtl/core/clp_dp.sv
rtl/core/clp_ctrl.sv
rtl/core/triangle_near_plane_clipper.sv
test/triangle_near_plane_clipper_tb.sv
